/* design/trc_pkg.sv */
// Shared types and constants for the triangle root compander.
`default_nettype none

package trc_pkg;

    localparam int unsigned OperandW = 16;
    localparam int unsigned CodeW    = 8;
    localparam int unsigned RootW    = 9;
    localparam int unsigned RemW     = 20;
    localparam int unsigned NumCells = RootW;

    localparam logic OP_COMPRESS = 1'b0;
    localparam logic OP_EXPAND   = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             op;
        logic [RemW-1:0]  acc;
        logic [RootW-1:0] root;
        logic [CodeW-1:0] code;
    } t_cell_data;

endpackage

`default_nettype wire

/* design/trc_cell.sv */
// One cell of the chain: one root bit (compress) or one multiplier bit (expand).
`default_nettype none

module trc_cell #(
    parameter int unsigned Bit = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  trc_pkg::t_cell_data  i_data,
    output trc_pkg::t_cell_data  o_data
);

    localparam logic [trc_pkg::RemW-1:0] SqBit = trc_pkg::RemW'(1) << (2 * Bit);

    trc_pkg::t_cell_data r_data;
    trc_pkg::t_cell_data n_data;
    logic [trc_pkg::RemW-1:0] trial;
    logic [trc_pkg::RemW-1:0] addend;

    always_comb begin
        trial  = (trc_pkg::RemW'(i_data.root) << (Bit + 1)) + SqBit;
        addend = trc_pkg::RemW'(i_data.code) << Bit;
        n_data = i_data;
        if (i_data.op == trc_pkg::OP_COMPRESS) begin
            if (i_data.acc >= trial) begin
                n_data.acc       = i_data.acc - trial;
                n_data.root[Bit] = 1'b1;
            end
        end else begin
            if (i_data.root[Bit]) begin
                n_data.acc = i_data.acc + addend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* design/triangle_root_compander_core.sv */
// Top level of the triangle root compander: input setup, cell chain, output register.
`default_nettype none

// Each item is either compressed (16-bit value to the code (isqrt(4v+1)-1)/2)
// or expanded (8-bit code n to n*(n+1)). Items enter one per cycle and pass a
// chain of nine cells, one per root or multiplier bit, then an output
// register; throughput is one item per cycle while the chain advances. The whole
// chain advances whenever the output register is empty or being taken.

module triangle_root_compander_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [15:0] operand
    input  wire  [0:0]  i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] result_value
);

    localparam int unsigned NumCells = trc_pkg::NumCells;

    trc_pkg::t_cell_data chain [NumCells+1];
    trc_pkg::t_cell_data head;
    logic                advance;
    logic                r_valid;
    logic [15:0]         r_result;
    logic [15:0]         n_result;
    trc_pkg::t_cell_data last;

    assign advance    = !r_valid || i_m_tready;
    assign o_s_tready = advance;

    always_comb begin
        head.valid = i_s_tvalid;
        head.op    = i_s_tuser[0];
        head.code  = i_s_tdata[trc_pkg::CodeW-1:0];
        if (i_s_tuser[0] == trc_pkg::OP_COMPRESS) begin
            head.acc  = trc_pkg::RemW'({i_s_tdata, 2'b01});
            head.root = '0;
        end else begin
            head.acc  = '0;
            head.root = trc_pkg::RootW'(i_s_tdata[trc_pkg::CodeW-1:0]) + trc_pkg::RootW'(1);
        end
    end

    assign chain[0] = head;

    for (genvar k = 0; k < NumCells; k++) begin : g_cell
        trc_cell #(
            .Bit (NumCells - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_data  (chain[k]),
            .o_data  (chain[k+1])
        );
    end

    assign last = chain[NumCells];

    always_comb begin
        if (last.op == trc_pkg::OP_COMPRESS) begin
            n_result = 16'((last.root - trc_pkg::RootW'(1)) >> 1);
        end else begin
            n_result = last.acc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid  <= last.valid;
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_result;

endmodule

`default_nettype wire
